// ===== hdl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_W   = 16;
	localparam int OUT_FRAC = 16;
	localparam int VAL_W    = 32;
	localparam int KIND_W   = 2;
	localparam int DISC_W   = 34;
	localparam int NB_W     = COEF_W + OUT_FRAC + 1;
	localparam int ROOT_W   = 33;
	localparam int REM_W    = 37;
	localparam int SQ_ST    = 33;
	localparam int DEN_W    = COEF_W + 2;
	localparam int NUM_W    = 36;
	localparam int UD_W     = 17;
	localparam int DIV_LAT  = NUM_W + 2;
	localparam int Q_DEPTH  = 4;
	localparam int Q_AW     = 2;

	localparam logic [KIND_W-1:0] KIND_TWO_REAL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DOUBLE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPLEX  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DEGEN    = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic signed [NB_W-1:0] nb;
		logic [DISC_W-1:0]      mag;
		logic signed [DEN_W-1:0] den;
	} qrs_entry_t;

endpackage

// ===== hdl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c from Q8.8 coefficients, results in Q16.16.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                          tuser
//  s_axis   in   a[15:0] b[31:16] c[47:32]       -
//  m_axis   out  first[31:0] second[63:32]      kind[1:0] saturated[2]
//
//  one triple per cycle sustained while the output is not stalled
//  the back end holds the 33-stage square root and the 38-stage dividers
//  a 4-beat queue separates the discriminant front from the back end
//  arst_n clears all valid flags and the queue pointers
//  a stalled output freezes the back end; the front fills the queue
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // coef_quad, coef_lin, coef_const
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // value_first, value_second
	output logic [2:0]  m_tuser    // root_kind, saturated
);

	logic                    push, full, empty, pop;
	qrs_entry_t              wr_entry, rd_entry;
	logic [KIND_W-1:0]       kind;
	logic signed [VAL_W-1:0] first, second;
	logic                    sat;

	qrs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.coef_quad  (s_tdata[15:0]),
		.coef_lin   (s_tdata[31:16]),
		.coef_const (s_tdata[47:32]),
		.push       (push),
		.entry      (wr_entry),
		.full       (full)
	);

	qrs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.rd_entry (rd_entry)
	);

	qrs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (empty),
		.q_entry    (rd_entry),
		.q_pop      (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (kind),
		.out_first  (first),
		.out_second (second),
		.out_sat    (sat)
	);

	assign m_tdata = {second, first};
	assign m_tuser = {sat, kind};

endmodule

// ===== hdl/qrs_front.sv =====
// ----------------------------------------------------------------------------
// qrs_front
// Forms the discriminant, classifies the equation and builds a queue entry.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [COEF_W-1:0] coef_quad,
	input  logic signed [COEF_W-1:0] coef_lin,
	input  logic signed [COEF_W-1:0] coef_const,
	output logic                     push,
	output qrs_entry_t               entry,
	input  logic                     full
);

	logic                          en;
	logic                          v_s1, v_s2;
	logic signed [COEF_W-1:0]      a_s1, b_s1;
	logic signed [2*COEF_W-1:0]    bb_s1, ac_s1;
	logic signed [DISC_W-1:0]      d;
	qrs_entry_t                    ent_d, ent_s2;

	assign en       = !v_s2 || !full;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= coef_quad;
			b_s1   <= coef_lin;
			bb_s1  <= coef_lin * coef_lin;
			ac_s1  <= coef_quad * coef_const;
			ent_s2 <= ent_d;
		end
	end

	always_comb begin
		d = DISC_W'(bb_s1) - (DISC_W'(ac_s1) <<< 2);
		ent_d.nb  = -(NB_W'(b_s1) <<< OUT_FRAC);
		ent_d.den = DEN_W'(a_s1) <<< 1;
		ent_d.mag = d[DISC_W-1] ? DISC_W'(-d) : DISC_W'(d);
		if (a_s1 == '0) begin
			ent_d.kind = KIND_DEGEN;
		end else if (d == '0) begin
			ent_d.kind = KIND_DOUBLE;
		end else if (d[DISC_W-1]) begin
			ent_d.kind = KIND_COMPLEX;
		end else begin
			ent_d.kind = KIND_TWO_REAL;
		end
	end

	assign push  = v_s2 && !full;
	assign entry = ent_s2;

endmodule

// ===== hdl/qrs_queue.sv =====
// ----------------------------------------------------------------------------
// qrs_queue
// Short queue between the classifying front and the arithmetic back end.
// ----------------------------------------------------------------------------
module qrs_queue import qrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  qrs_entry_t wr_entry,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output qrs_entry_t rd_entry
);

	qrs_entry_t       mem_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]    count_q;
	logic             do_pop;

	assign full     = count_q == (Q_AW+1)'(Q_DEPTH);
	assign empty    = count_q == '0;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined digit-by-digit square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  qrs_entry_t        in_entry,
	output logic              out_valid,
	output qrs_entry_t        out_entry,
	output logic [ROOT_W-1:0] out_root
);

	logic              v_q   [SQ_ST];
	qrs_entry_t        ent_q [SQ_ST];
	logic [DISC_W-1:0] mag_q [SQ_ST];
	logic [ROOT_W-1:0] root_q[SQ_ST];
	logic [REM_W-1:0]  rem_q [SQ_ST];

	for (genvar k = 0; k < SQ_ST; k++) begin : g_st
		logic              v_i;
		qrs_entry_t        ent_i;
		logic [DISC_W-1:0] mag_i;
		logic [ROOT_W-1:0] root_i;
		logic [REM_W-1:0]  rem_i, rem_sh, trial;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign ent_i  = in_entry;
			assign mag_i  = in_entry.mag;
			assign root_i = '0;
			assign rem_i  = '0;
		end else begin : g_next
			assign v_i    = v_q[k-1];
			assign ent_i  = ent_q[k-1];
			assign mag_i  = mag_q[k-1];
			assign root_i = root_q[k-1];
			assign rem_i  = rem_q[k-1];
		end

		assign rem_sh = {rem_i[REM_W-3:0], mag_i[DISC_W-1 -: 2]};
		assign trial  = {2'b00, root_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ent_q[k] <= ent_i;
				mag_q[k] <= mag_i << 2;
				if (rem_sh >= trial) begin
					rem_q[k]  <= rem_sh - trial;
					root_q[k] <= {root_i[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q[k]  <= rem_sh;
					root_q[k] <= {root_i[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_q[SQ_ST-1];
	assign out_entry = ent_q[SQ_ST-1];
	assign out_root  = root_q[SQ_ST-1];

endmodule

// ===== hdl/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, rounds half away from zero and saturates.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic signed [VAL_W-1:0] quot,
	output logic                    clip
);

	logic             neg_q [NUM_W+1];
	logic [UD_W-1:0]  ud_q  [NUM_W+1];
	logic [NUM_W-1:0] u_q   [NUM_W+1];
	logic [NUM_W-1:0] q_q   [NUM_W+1];
	logic [UD_W-1:0]  r_q   [NUM_W+1];
	logic [NUM_W-1:0] un;
	logic [UD_W-1:0]  ud;

	assign un = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign ud = den[DEN_W-1] ? UD_W'(-den) : UD_W'(den);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_q[0] <= num[NUM_W-1] ^ den[DEN_W-1];
			ud_q[0]  <= ud;
			u_q[0]   <= un + NUM_W'(ud >> 1);
			q_q[0]   <= '0;
			r_q[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= NUM_W; k++) begin : g_st
		logic [UD_W:0] t;
		assign t = {r_q[k-1], u_q[k-1][NUM_W-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				neg_q[k] <= neg_q[k-1];
				ud_q[k]  <= ud_q[k-1];
				u_q[k]   <= u_q[k-1] << 1;
				if (t >= {1'b0, ud_q[k-1]}) begin
					r_q[k] <= UD_W'(t - {1'b0, ud_q[k-1]});
					q_q[k] <= {q_q[k-1][NUM_W-2:0], 1'b1};
				end else begin
					r_q[k] <= UD_W'(t);
					q_q[k] <= {q_q[k-1][NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_q[NUM_W]) begin
				if (q_q[NUM_W] > NUM_W'(64'h8000_0000)) begin
					clip <= 1'b1;
					quot <= {1'b1, {(VAL_W-1){1'b0}}};
				end else begin
					clip <= 1'b0;
					quot <= VAL_W'(-q_q[NUM_W]);
				end
			end else begin
				if (q_q[NUM_W] > NUM_W'(64'h7FFF_FFFF)) begin
					clip <= 1'b1;
					quot <= {1'b0, {(VAL_W-1){1'b1}}};
				end else begin
					clip <= 1'b0;
					quot <= VAL_W'(q_q[NUM_W]);
				end
			end
		end
	end

endmodule

// ===== hdl/qrs_back.sv =====
// ----------------------------------------------------------------------------
// qrs_back
// Square root, numerator forming, two dividers and the output register.
// ----------------------------------------------------------------------------
module qrs_back import qrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  qrs_entry_t               q_entry,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [KIND_W-1:0]        out_kind,
	output logic signed [VAL_W-1:0]  out_first,
	output logic signed [VAL_W-1:0]  out_second,
	output logic                     out_sat
);

	logic                     en;
	logic                     sq_v;
	qrs_entry_t               sq_ent;
	logic [ROOT_W-1:0]        sq_root;
	logic                     v_s1;
	logic [KIND_W-1:0]        kind_s1;
	logic signed [NUM_W-1:0]  n1_s1, n2_s1;
	logic signed [DEN_W-1:0]  d1_s1, d2_s1;
	logic signed [NUM_W-1:0]  nb_x, s_x;
	logic                     v_q   [DIV_LAT];
	logic [KIND_W-1:0]        kind_q[DIV_LAT];
	logic signed [VAL_W-1:0]  v1, v2;
	logic                     c1, c2;
	logic                     out_valid_q;

	assign en    = !out_valid_q || out_ready;
	assign q_pop = en;

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (!q_empty),
		.in_entry  (q_entry),
		.out_valid (sq_v),
		.out_entry (sq_ent),
		.out_root  (sq_root)
	);

	assign nb_x = NUM_W'(sq_ent.nb);
	assign s_x  = NUM_W'(sq_root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= sq_ent.kind;
			d1_s1   <= sq_ent.den;
			case (sq_ent.kind)
				KIND_TWO_REAL: begin
					n1_s1 <= nb_x + s_x;
					n2_s1 <= nb_x - s_x;
					d2_s1 <= sq_ent.den;
				end
				KIND_COMPLEX: begin
					n1_s1 <= nb_x;
					n2_s1 <= s_x;
					d2_s1 <= sq_ent.den[DEN_W-1] ? -sq_ent.den : sq_ent.den;
				end
				default: begin
					n1_s1 <= nb_x;
					n2_s1 <= nb_x;
					d2_s1 <= sq_ent.den;
				end
			endcase
		end
	end

	qrs_div u_div_first (
		.clk  (clk),
		.en   (en),
		.num  (n1_s1),
		.den  (d1_s1),
		.quot (v1),
		.clip (c1)
	);

	qrs_div u_div_second (
		.clk  (clk),
		.en   (en),
		.num  (n2_s1),
		.den  (d2_s1),
		.quot (v2),
		.clip (c2)
	);

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_tag
		logic              v_i;
		logic [KIND_W-1:0] k_i;
		if (k == 0) begin : g_first
			assign v_i = v_s1;
			assign k_i = kind_s1;
		end else begin : g_next
			assign v_i = v_q[k-1];
			assign k_i = kind_q[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				kind_q[k] <= k_i;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_kind <= kind_q[DIV_LAT-1];
			if (kind_q[DIV_LAT-1] == KIND_DEGEN) begin
				out_first  <= '0;
				out_second <= '0;
				out_sat    <= 1'b0;
			end else begin
				out_first  <= v1;
				out_second <= v2;
				out_sat    <= c1 || c2;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks on the result stream of the quadratic root solver.
// ----------------------------------------------------------------------------
module qrs_checker import qrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [2:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == KIND_DEGEN |-> m_tdata == '0 && !m_tuser[2])
		else $error("degenerate beat not zero");

	a_double: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == KIND_DOUBLE |-> m_tdata[31:0] == m_tdata[63:32])
		else $error("double root values differ");

	a_imag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == KIND_COMPLEX |-> !m_tdata[63])
		else $error("negative imaginary magnitude");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
